// ----- hw/rtl/orle_pkg.sv -----
// ----------------------------------------------------------------------------
// orle_pkg
// Shared types and codes of the ordered record list engine: the record
// layout, operation codes, status codes and the default list capacity.
// ----------------------------------------------------------------------------
package orle_pkg;

    // Default number of records the list holds
    localparam int ORLE_CAPACITY = 8;

    // Operation codes
    localparam logic [1:0] FN_INSERT  = 2'd0;
    localparam logic [1:0] FN_DEL_KEY = 2'd1;
    localparam logic [1:0] FN_DEL_TAG = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // One stored record
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] tag;
        logic [63:0] payload;
    } rec_t;

endpackage

// ----- hw/rtl/ordered_record_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// ordered_record_list_engine_core
// Ordered list of up to CAPACITY records with insert at a position, delete
// by key and delete of all records carrying a tag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one operation word: func,
//   position, rec_key, rec_tag, rec_payload. Output channel (out_valid /
//   out_stall) returns one result word per operation: status, the removed
//   record, removed_count and the new entry_count.
//   Records sit in a single-port-write, single-port-read RAM; a sequencer
//   streams one record per cycle through it, so the RAM read port sets the
//   rate. An insert moves the records from position to the end up by one and
//   then writes the new record at position; a delete reads every record; a
//   full list or an unused code goes straight to the result. The next word is
//   taken in the cycle after the result is loaded. in_stall is high while an
//   operation is running or its result cannot yet be loaded.
//   The result register lets the next operation start while a previous
//   result still waits; a stalled receiver holds that result and only
//   blocks the following operation at its final step.
//   Reset clears the count to zero and empties the output register; record
//   storage is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module ordered_record_list_engine_core #(
    parameter int CAPACITY = orle_pkg::ORLE_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  position,
    input  logic [31:0] rec_key,
    input  logic [15:0] rec_tag,
    input  logic [63:0] rec_payload,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] removed_key,
    output logic [15:0] removed_tag,
    output logic [63:0] removed_payload,
    output logic [3:0]  removed_count,
    output logic [3:0]  entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]     state_reg;
    logic [1:0]     func_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  p_reg;
    logic [CW-1:0]  scan_reg;
    logic [CW-1:0]  kept_reg;
    logic [CW-1:0]  rcnt_reg;
    logic           vq_reg;
    logic [AW-1:0]  src_reg;
    logic           found_reg;
    logic [1:0]     status_reg;
    logic [31:0]    key_reg;
    logic [15:0]    tag_reg;
    logic [63:0]    payload_reg;
    orle_pkg::rec_t cap_reg;

    logic           out_valid_reg;
    logic [1:0]     out_status_reg;
    logic [31:0]    out_key_reg;
    logic [15:0]    out_tag_reg;
    logic [63:0]    out_payload_reg;
    logic [3:0]     out_rcnt_reg;
    logic [3:0]     out_count_reg;

    logic           in_accept;
    logic           is_ins;
    logic           issue;
    logic           finish;
    logic           fin_load;
    logic           key_hit;
    logic           tag_hit;
    logic [CW-1:0]  pos_clamp;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    orle_pkg::rec_t wr_data;
    orle_pkg::rec_t rd_data;

    // Handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign fin_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // Clamp the insert position to the count
    always_comb
    begin
        if (PW'(position) > PW'(count_reg))
        begin
            pos_clamp = count_reg;
        end
        else
        begin
            pos_clamp = CW'(position);
        end
    end

    // Scan sequencer: pick the next read and detect the end of the pass
    always_comb
    begin
        is_ins  = (func_reg == orle_pkg::FN_INSERT);
        if (is_ins)
        begin
            issue   = (state_reg == S_RUN) && (scan_reg > p_reg);
            rd_addr = AW'(scan_reg - CW'(1));
        end
        else
        begin
            issue   = (state_reg == S_RUN) && (scan_reg < count_reg);
            rd_addr = AW'(scan_reg);
        end
        finish  = (state_reg == S_RUN) && !issue && !vq_reg;
        key_hit = (rd_data.key == key_reg);
        tag_hit = (rd_data.tag == tag_reg);
    end

    // Write port: move arriving records, or place the new record at its position
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = src_reg;
        wr_data = rd_data;
        if (vq_reg)
        begin
            case (func_reg)
                orle_pkg::FN_INSERT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = src_reg + AW'(1);
                end
                orle_pkg::FN_DEL_KEY:
                begin
                    wr_en   = found_reg;
                    wr_addr = src_reg - AW'(1);
                end
                orle_pkg::FN_DEL_TAG:
                begin
                    wr_en   = !tag_hit;
                    wr_addr = AW'(kept_reg);
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (finish && is_ins)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(p_reg);
            wr_data = '{key: key_reg, tag: tag_reg, payload: payload_reg};
        end
    end

    orle_rec_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= orle_pkg::FN_INSERT;
            count_reg     <= '0;
            p_reg         <= '0;
            scan_reg      <= '0;
            kept_reg      <= '0;
            rcnt_reg      <= '0;
            vq_reg        <= 1'b0;
            src_reg       <= '0;
            found_reg     <= 1'b0;
            status_reg    <= orle_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a fresh result, or drop the one just taken
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        func_reg  <= func;
                        p_reg     <= pos_clamp;
                        kept_reg  <= '0;
                        rcnt_reg  <= '0;
                        found_reg <= 1'b0;
                        vq_reg    <= 1'b0;
                        if (func == orle_pkg::FN_INSERT)
                        begin
                            scan_reg <= count_reg;
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_reg <= orle_pkg::ST_FULL;
                                state_reg  <= S_FIN;
                            end
                            else
                            begin
                                status_reg <= orle_pkg::ST_OK;
                                state_reg  <= S_RUN;
                            end
                        end
                        else if (func inside {orle_pkg::FN_DEL_KEY, orle_pkg::FN_DEL_TAG})
                        begin
                            scan_reg   <= '0;
                            status_reg <= orle_pkg::ST_OK;
                            state_reg  <= S_RUN;
                        end
                        else
                        begin
                            status_reg <= orle_pkg::ST_OK;
                            state_reg  <= S_FIN;
                        end
                    end
                end
                S_RUN:
                begin
                    // Advance the read pointer
                    vq_reg  <= issue;
                    src_reg <= rd_addr;
                    if (issue)
                    begin
                        if (is_ins)
                        begin
                            scan_reg <= scan_reg - CW'(1);
                        end
                        else
                        begin
                            scan_reg <= scan_reg + CW'(1);
                        end
                    end
                    // Judge the arriving record
                    if (vq_reg)
                    begin
                        if (func_reg == orle_pkg::FN_DEL_KEY && !found_reg && key_hit)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (func_reg == orle_pkg::FN_DEL_TAG)
                        begin
                            if (tag_hit)
                            begin
                                rcnt_reg <= rcnt_reg + CW'(1);
                            end
                            else
                            begin
                                kept_reg <= kept_reg + CW'(1);
                            end
                        end
                    end
                    // Close the operation
                    if (finish)
                    begin
                        state_reg <= S_FIN;
                        case (func_reg)
                            orle_pkg::FN_INSERT:
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            orle_pkg::FN_DEL_KEY:
                            begin
                                if (found_reg)
                                begin
                                    count_reg <= count_reg - CW'(1);
                                end
                                else
                                begin
                                    status_reg <= orle_pkg::ST_NOT_FOUND;
                                end
                            end
                            orle_pkg::FN_DEL_TAG:
                            begin
                                count_reg <= kept_reg;
                            end
                            default:
                            begin
                                count_reg <= count_reg;
                            end
                        endcase
                    end
                end
                S_FIN:
                begin
                    if (fin_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold operands, the found record and the result word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg     <= rec_key;
            tag_reg     <= rec_tag;
            payload_reg <= rec_payload;
        end
        if (state_reg == S_RUN && vq_reg && func_reg == orle_pkg::FN_DEL_KEY &&
            !found_reg && key_hit)
        begin
            cap_reg <= rd_data;
        end
        if (fin_load)
        begin
            out_status_reg <= status_reg;
            out_rcnt_reg   <= 4'(rcnt_reg);
            out_count_reg  <= 4'(count_reg);
            if (found_reg)
            begin
                out_key_reg     <= cap_reg.key;
                out_tag_reg     <= cap_reg.tag;
                out_payload_reg <= cap_reg.payload;
            end
            else
            begin
                out_key_reg     <= '0;
                out_tag_reg     <= '0;
                out_payload_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign removed_key     = out_key_reg;
    assign removed_tag     = out_tag_reg;
    assign removed_payload = out_payload_reg;
    assign removed_count   = out_rcnt_reg;
    assign entry_count     = out_count_reg;

endmodule

// ----- hw/rtl/orle_rec_ram.sv -----
// ----------------------------------------------------------------------------
// orle_rec_ram
// Record storage: one write port and one read port with registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module orle_rec_ram #(
    parameter int DEPTH = orle_pkg::ORLE_CAPACITY,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  orle_pkg::rec_t wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output orle_pkg::rec_t rd_data
);

    orle_pkg::rec_t mem [DEPTH];
    orle_pkg::rec_t rd_data_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
